// ----- rtl/isrt_pkg.sv -----
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared constants and types for the insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package isrt_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned DATA_W    = 32;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast word
    logic shift;  // move every entry one place toward cell 0
  } isrt_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/isrt_cell.sv -----
// ----------------------------------------------------------------------------
// isrt_cell
// One place of the sorted chain: holds one entry and its valid bit, takes
// the new word, its lower neighbor's entry or its upper neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_cell import isrt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire isrt_ctrl_t        ctrl_i,
  input  wire logic [DATA_W-1:0] new_val_i,
  input  wire logic [DATA_W-1:0] lo_val_i,
  input  wire logic              lo_valid_i,
  input  wire logic              lo_gt_i,
  input  wire logic [DATA_W-1:0] hi_val_i,
  input  wire logic              hi_valid_i,
  output logic [DATA_W-1:0]      val_o,
  output logic                   valid_o,
  output logic                   gt_o
);

  logic [DATA_W-1:0] val_q, val_d;
  logic              valid_q, valid_d;

  // an empty place counts as greater than anything
  assign gt_o    = !valid_q || ($signed(val_q) > $signed(new_val_i));
  assign val_o   = val_q;
  assign valid_o = valid_q;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.ins) begin
      if (lo_gt_i) begin
        // lower neighbor is already displaced: shift up
        val_d   = lo_val_i;
        valid_d = lo_valid_i;
      end else if (gt_o) begin
        val_d   = new_val_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      val_d   = hi_val_i;
      valid_d = hi_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// ----- rtl/insertion_sorter_core.sv -----
// An accepted word is registered in its sorted place in the next cycle.
// Throughput: one input word per cycle while a set is being collected.
// After the word marked last, the first result appears the next cycle and
// the set drains at one result per cycle from cell 0 while the output is
// ready; input waits during the drain.
// Reset: all cells empty, overflow flag and drain state cleared.
// ----------------------------------------------------------------------------
// insertion_sorter_core
// Systolic insertion sorter: a chain of cells keeps the set in ascending
// order and shifts it out through cell 0 when the last word arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter_core import isrt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [DATA_W-1:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic              s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [DATA_W-1:0]      m_axis_tdata_o,   // [31:0] sorted_value
  output logic                   m_axis_tlast_o,
  output logic                   m_axis_tuser_o    // [0] overflowed
);

  logic [DATA_W-1:0] val   [MAX_ITEMS];
  logic              valid [MAX_ITEMS];
  logic              gt    [MAX_ITEMS];

  logic       drain_q, drain_d;
  logic       drop_q, drop_d;
  logic       in_fire, out_fire, full;
  isrt_ctrl_t ctrl;

  assign full     = valid[MAX_ITEMS-1];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  assign ctrl.ins   = in_fire && !full;
  assign ctrl.shift = out_fire;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [DATA_W-1:0] lo_val, hi_val;
    logic              lo_valid, lo_gt, hi_valid;

    if (i == 0) begin : g_first
      assign lo_val   = '0;
      assign lo_valid = 1'b0;
      assign lo_gt    = 1'b0;
    end else begin : g_mid_lo
      assign lo_val   = val[i-1];
      assign lo_valid = valid[i-1];
      assign lo_gt    = gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_top
      assign hi_val   = '0;
      assign hi_valid = 1'b0;
    end else begin : g_mid_hi
      assign hi_val   = val[i+1];
      assign hi_valid = valid[i+1];
    end

    isrt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_val_i  (s_axis_tdata_i),
      .lo_val_i   (lo_val),
      .lo_valid_i (lo_valid),
      .lo_gt_i    (lo_gt),
      .hi_val_i   (hi_val),
      .hi_valid_i (hi_valid),
      .val_o      (val[i]),
      .valid_o    (valid[i]),
      .gt_o       (gt[i])
    );
  end

  assign s_axis_tready_o = !drain_q;
  assign m_axis_tvalid_o = drain_q;
  assign m_axis_tdata_o  = val[0];
  assign m_axis_tlast_o  = !valid[1];
  assign m_axis_tuser_o  = drop_q;

  always_comb begin
    drain_d = drain_q;
    drop_d  = drop_q;
    if (in_fire) begin
      if (full) begin
        drop_d = 1'b1;
      end
      if (s_axis_tlast_i) begin
        drain_d = 1'b1;
      end
    end
    // clear set state once the final word leaves
    if (out_fire && m_axis_tlast_o) begin
      drain_d = 1'b0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      drain_q <= drain_d;
      drop_q  <= drop_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/isrt_checker.sv -----
// ----------------------------------------------------------------------------
// isrt_checker
// Port-level checks for the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        s_axis_tlast_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o,
  input wire logic        m_axis_tuser_o
);

  // input waits while a set drains
  a_no_input_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready during drain");

  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("no result after last input word");

  a_idle_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("output still valid after final result");

  a_flag_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && (m_axis_tuser_o == $past(m_axis_tuser_o))))
    else $error("run broken or overflow flag changed within run");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled output word changed");

endmodule

bind insertion_sorter_core isrt_checker u_isrt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
